/* rtl/core/kfssp_pkg.sv */
// Package: fixed-point constants, register codes and the quarter-wave sine table.
`timescale 1ns / 1ps

package kfssp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_IDX_W  = $clog2(SINE_DEPTH + 1);
    localparam int RND_SH      = 24 - FRAC_BITS;

    // Serial step counts
    localparam int DIV_STEPS   = 56;   // (p' << 24) / (p' + r)
    localparam int MUL_STEPS   = 25;   // multiplier operands are the Q1.24 gain and one minus it
    localparam int TMUL_STEPS  = 32;   // time * turns per second
    localparam int FDIV_STEPS  = 31;   // turns per frame / fps

    // Register codes
    localparam logic [1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [1:0] CFG_MEASURE_NOISE = 2'd1;
    localparam logic [1:0] CFG_INITIAL_COV   = 2'd2;

    localparam logic [31:0] PROCESS_NOISE_RST = 32'd168;
    localparam logic [31:0] MEASURE_NOISE_RST = 32'd1678;
    localparam logic [31:0] INITIAL_COV_RST   = 32'd16777216;
    localparam logic [31:0] CURVE_PRED_RST    = 32'd1 << FRAC_BITS;

    localparam logic [24:0] GAIN_ONE       = 25'h1000000;
    localparam logic [27:0] TURNS_PER_SEC  = 28'd268031071;
    localparam logic [30:0] TURNS_PER_FRM  = 31'd1287836979;
    localparam logic [29:0] CURVE_AMP      = 30'd754591986;
    localparam logic [30:0] CURVE_OFF      = 31'd1254449098;
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0] ONE_Q30        = 64'd1073741824;
    localparam logic [49:0] CURVE_HALF     = 50'((64'd1 << RND_SH) >> 1);

    typedef logic [31:0] sine_tab_t [0:SINE_DEPTH];

    // Q30 sine of a Q30 angle in [0, pi/2], Horner form of the Taylor series
    function automatic logic [31:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] res;
        x2  = (x * x) >> 30;
        acc = ONE_Q30;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd156;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd110;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd72;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd42;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd20;
        acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd6;
        res = (x * acc) >> 30;
        return res[31:0];
    endfunction

    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            tab[k] = sin_q30((64'(k) * HALF_PI_Q30) / SINE_DEPTH);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage

/* rtl/core/kalman_filter_sine_speed_prior.sv */
// Top level: scalar Kalman speed filter with a sine speed-curve prior, bit-serial datapath.
`timescale 1ns / 1ps

// One measurement beat in, one estimate beat out. Each item runs through a
// sequencer: a prepare state forms p' + r and the innovation, the restoring
// divider forms the Q1.24 gain (the curve phase multiply and the
// turns-per-frame division run bit-serially alongside it), shift-add
// multiplication forms the correction and the new covariance, then the
// finishing states do the phase, the sine table read and the curve scaling.
// The divider sets the pace; the input is closed from an accepted beat until
// the item leaves the done state. The output register lets the next item be taken
// while an estimate still waits. Configuration writes are always taken;
// write them only while the block is idle. p takes the reset value of
// initial_covariance at reset only; a written value is never loaded into p.
module kalman_filter_sine_speed_prior
    import kfssp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // measurement[31:0], time_now[63:32], frame_rate[71:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // estimate[31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_FIN1 = 4'd4;
    localparam logic [3:0] S_FIN2 = 4'd5;
    localparam logic [3:0] S_FIN3 = 4'd6;
    localparam logic [3:0] S_FIN4 = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;

    // configuration and filter state
    logic [31:0] q_reg, r_reg, pinit_reg;
    logic [31:0] p_reg, pred_reg;

    // latched item
    logic [31:0] z_reg, t_reg;
    logic [7:0]  fps_reg;

    logic [31:0] pp_reg;
    logic [32:0] den_reg;
    logic        diff_neg_reg;
    logic [32:0] diff_mag_reg;

    // gain divider
    logic [55:0] num_reg;
    logic [33:0] rem_reg;
    logic [24:0] quo_reg;
    // turns-per-frame divider
    logic [30:0] fnum_reg, fquo_reg;
    logic [8:0]  frem_reg;
    // time multiplier
    logic [27:0] th_reg;
    logic [31:0] tl_reg;
    // correction and covariance multipliers
    logic [32:0] ah_reg;
    logic [24:0] al_reg;
    logic [31:0] bh_reg;
    logic [24:0] bl_reg;

    logic [31:0]           est_reg;
    logic [SINE_IDX_W-1:0] rom_addr_reg;
    logic                  sneg_reg;
    logic [30:0]           sine_reg;
    logic [60:0]           amp_prod_reg;

    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic in_fire, out_load;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // p' = p + q, saturated
    logic [32:0] pp_sum;
    logic [31:0] pp_sat;
    assign pp_sum = {1'b0, p_reg} + {1'b0, q_reg};
    assign pp_sat = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];

    // innovation z - pred
    logic [32:0] diff;
    assign diff = {z_reg[31], z_reg} - {pred_reg[31], pred_reg};

    // divider steps
    logic [33:0] rem_sh, rem_next;
    logic        q_bit;
    logic [24:0] quo_next;
    logic [24:0] gain;
    assign rem_sh   = {rem_reg[32:0], num_reg[55]};
    assign q_bit    = rem_sh >= {1'b0, den_reg};
    assign rem_next = q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;
    assign quo_next = {quo_reg[23:0], q_bit};
    assign gain     = (den_reg == 33'd0) ? 25'd0 : quo_next;

    logic [7:0]  fdv;
    logic [8:0]  frem_sh, frem_next;
    logic        fq_bit;
    assign fdv       = (fps_reg == 8'd0) ? 8'd1 : fps_reg;
    assign frem_sh   = {frem_reg[7:0], fnum_reg[30]};
    assign fq_bit    = frem_sh >= {1'b0, fdv};
    assign frem_next = fq_bit ? frem_sh - {1'b0, fdv} : frem_sh;

    logic [28:0] tsum;
    assign tsum = {1'b0, th_reg} + (tl_reg[0] ? {1'b0, TURNS_PER_SEC} : 29'd0);

    logic [33:0] asum;
    logic [32:0] bsum;
    assign asum = {1'b0, ah_reg} + (al_reg[0] ? {1'b0, diff_mag_reg} : 34'd0);
    assign bsum = {1'b0, bh_reg} + (bl_reg[0] ? {1'b0, pp_reg} : 33'd0);

    // finish: estimate, covariance, phase
    logic [58:0] corr_sum;
    logic [34:0] corr;
    logic [35:0] x_full;
    logic [31:0] x_sat;
    logic [56:0] pprod;
    logic [31:0] newp;
    logic [59:0] tprod;
    logic [31:0] phase;
    logic [30+SINE_IDX_W-1:0] idx_prod;
    logic [SINE_IDX_W-1:0]    idx_raw, idx_clamp, rom_addr;

    assign corr_sum = {1'b0, ah_reg, al_reg} + 59'(64'd1 << 23);
    assign corr     = corr_sum[58:24];
    assign x_full   = diff_neg_reg ? {{4{pred_reg[31]}}, pred_reg} - {1'b0, corr}
                                   : {{4{pred_reg[31]}}, pred_reg} + {1'b0, corr};
    always_comb
    begin
        if (x_full[35:31] == 5'b00000 || x_full[35:31] == 5'b11111)
            x_sat = x_full[31:0];
        else if (x_full[35])
            x_sat = 32'h8000_0000;
        else
            x_sat = 32'h7FFF_FFFF;
    end

    assign pprod    = {bh_reg, bl_reg};
    assign newp     = pprod[55:24];
    assign tprod    = {th_reg, tl_reg};
    assign phase    = tprod[FRAC_BITS+31:FRAC_BITS] + {1'b0, fquo_reg};
    assign idx_prod = (30+SINE_IDX_W)'(phase[29:0]) * (30+SINE_IDX_W)'(SINE_DEPTH);
    assign idx_raw  = idx_prod[30+SINE_IDX_W-1:30];
    assign idx_clamp = (idx_raw > SINE_IDX_W'(SINE_DEPTH - 1)) ?
                       SINE_IDX_W'(SINE_DEPTH - 1) : idx_raw;
    assign rom_addr = phase[30] ? SINE_IDX_W'(SINE_DEPTH) - idx_clamp : idx_clamp;

    // curve scaling
    logic [61:0] part_sum;
    logic [31:0] part;
    logic [49:0] a24, a24_rnd;
    logic [31:0] curve;
    assign part_sum = {1'b0, amp_prod_reg} + 62'(64'd1 << 29);
    assign part     = part_sum[61:30];
    assign a24      = sneg_reg ? {19'd0, CURVE_OFF} - {18'd0, part}
                               : {19'd0, CURVE_OFF} + {18'd0, part};
    assign a24_rnd  = a24 + CURVE_HALF;
    assign curve    = a24_rnd[RND_SH+31:RND_SH];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_PREP;
            S_PREP:
            begin
                state_next = S_DIV;
                cnt_next   = 6'd0;
            end
            S_DIV:
            begin
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = S_MUL;
                    cnt_next   = 6'd0;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_MUL:
            begin
                if (cnt_reg == 6'(MUL_STEPS - 1))
                    state_next = S_FIN1;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_FIN1: state_next = S_FIN2;
            S_FIN2: state_next = S_FIN3;
            S_FIN3: state_next = S_FIN4;
            S_FIN4: state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 6'd0;
            q_reg         <= PROCESS_NOISE_RST;
            r_reg         <= MEASURE_NOISE_RST;
            pinit_reg     <= INITIAL_COV_RST;
            p_reg         <= INITIAL_COV_RST;
            pred_reg      <= CURVE_PRED_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE: q_reg     <= cfg_data;
                    CFG_MEASURE_NOISE: r_reg     <= cfg_data;
                    CFG_INITIAL_COV:   pinit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_FIN1)
                p_reg <= newp;
            if (state_reg == S_FIN4)
                pred_reg <= curve;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            z_reg   <= s_axis_tdata[31:0];
            t_reg   <= s_axis_tdata[63:32];
            fps_reg <= s_axis_tdata[71:64];
            pp_reg  <= pp_sat;
        end
        if (state_reg == S_PREP)
        begin
            den_reg      <= {1'b0, pp_reg} + {1'b0, r_reg};
            diff_neg_reg <= diff[32];
            diff_mag_reg <= diff[32] ? 33'd0 - diff : diff;
            num_reg      <= {pp_reg, 24'd0};
            rem_reg      <= 34'd0;
            fnum_reg     <= TURNS_PER_FRM;
            frem_reg     <= 9'd0;
            th_reg       <= 28'd0;
            tl_reg       <= t_reg;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            num_reg <= {num_reg[54:0], 1'b0};
            if (cnt_reg < 6'(FDIV_STEPS))
            begin
                frem_reg <= frem_next;
                fquo_reg <= {fquo_reg[29:0], fq_bit};
                fnum_reg <= {fnum_reg[29:0], 1'b0};
            end
            if (cnt_reg < 6'(TMUL_STEPS))
            begin
                th_reg <= tsum[28:1];
                tl_reg <= {tsum[0], tl_reg[31:1]};
            end
            if (cnt_reg == 6'(DIV_STEPS - 1))
            begin
                ah_reg <= 33'd0;
                al_reg <= gain;
                bh_reg <= 32'd0;
                bl_reg <= GAIN_ONE - gain;
            end
        end
        if (state_reg == S_MUL)
        begin
            ah_reg <= asum[33:1];
            al_reg <= {asum[0], al_reg[24:1]};
            bh_reg <= bsum[32:1];
            bl_reg <= {bsum[0], bl_reg[24:1]};
        end
        if (state_reg == S_FIN1)
        begin
            est_reg      <= x_sat;
            rom_addr_reg <= rom_addr;
            sneg_reg     <= phase[31];
        end
        if (state_reg == S_FIN2)
            sine_reg <= SINE_TAB[rom_addr_reg][30:0];
        if (state_reg == S_FIN3)
            amp_prod_reg <= 61'(CURVE_AMP) * 61'(sine_reg);
        if (out_load)
            out_data_reg <= est_reg;
    end

    // the gain never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && cnt_reg == 6'd0) |-> (al_reg <= GAIN_ONE))
        else $error("gain above one");

    // the updated covariance never exceeds p'
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN1) |-> (newp <= pp_reg))
        else $error("covariance grew through the update");

    // an accepted beat closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input reopened during an item");

    // the step counter stays inside the divider phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < 6'(DIV_STEPS)))
        else $error("divider step count overran");

    // a result is only loaded from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside done state");

endmodule
